@@ rtl/cvfb_pkg.sv @@
// Channel vocoder filter bank: shared types and constants.
// Used by the front end, back end and top level; depends on nothing.
package cvfb_pkg;

	localparam int SAMPLE_W = 24;
	localparam int HIST_W   = 32;
	localparam int ENV_W    = 31;
	localparam int ACC_W    = 64;
	localparam int NUM_SLOTS = 5;

	localparam logic CMD_AUDIO = 1'b0;
	localparam logic CMD_COEF  = 1'b1;

	localparam logic [2:0] SLOT_A1 = 3'd0;
	localparam logic [2:0] SLOT_A2 = 3'd1;
	localparam logic [2:0] SLOT_B0 = 3'd2;
	localparam logic [2:0] SLOT_B1 = 3'd3;
	localparam logic [2:0] SLOT_B2 = 3'd4;

	localparam logic [1:0] CFG_BAND_MODE = 2'd0;
	localparam logic [1:0] CFG_RELEASE   = 2'd1;
	localparam logic [1:0] CFG_GAIN      = 2'd2;

	localparam logic [22:0] RELEASE_RST = 23'd8388433;
	localparam logic [15:0] GAIN_RST    = 16'd1311;

	// saw step = 380*f + round-floor((19216*f + 22050) / 44100)
	localparam logic [8:0]  SAW_INT      = 9'd380;
	localparam logic [14:0] SAW_FRAC_NUM = 15'd19216;
	localparam logic [14:0] SAW_HALF     = 15'd22050;
	localparam logic [15:0] SAW_DEN      = 16'd44100;
	localparam logic [16:0] SAW_RECIP    = 17'd97391;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_AUDIO = 2'd1,
		KIND_COEF  = 2'd2
	} item_kind_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [4:0]  band;
		logic [2:0]  slot;
		logic [31:0] value;
		logic [23:0] left;
		logic [23:0] right;
		logic [10:0] freq;
	} item_t;

	typedef struct packed {
		logic        band_mode;
		logic [22:0] release_coef;
		logic [15:0] voice_gain;
	} cfg_t;

endpackage

@@ rtl/cvfb_front.sv @@
// Front end: accepts input transactions, classifies them and queues them.
// Depends on cvfb_pkg.
module cvfb_front #(
	parameter int MAX_BANDS = 28
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                cmd,
	input  logic [23:0]         voice_left,
	input  logic [23:0]         voice_right,
	input  logic [10:0]         carrier_freq,
	input  logic [4:0]          coef_band,
	input  logic [2:0]          coef_slot,
	input  logic [31:0]         coef_value,
	output cvfb_pkg::item_t     q_item,
	output logic                q_valid,
	input  logic                q_pop
);

	cvfb_pkg::item_t item_in;
	cvfb_pkg::item_t fifo_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            pop;

	always_comb begin
		item_in.band  = coef_band;
		item_in.slot  = coef_slot;
		item_in.value = coef_value;
		item_in.left  = voice_left;
		item_in.right = voice_right;
		item_in.freq  = carrier_freq;
		if (cmd == cvfb_pkg::CMD_COEF) begin
			if (int'(coef_band) < MAX_BANDS && int'(coef_slot) < cvfb_pkg::NUM_SLOTS)
				item_in.kind = cvfb_pkg::KIND_COEF;
			else
				item_in.kind = cvfb_pkg::KIND_NONE;
		end else begin
			item_in.kind = cvfb_pkg::KIND_AUDIO;
		end
	end

	assign in_ready = (count_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (count_q != 2'd0);
	assign pop      = q_pop && q_valid;
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			fifo_q[wr_ptr_q] <= item_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !pop)
				count_q <= count_q + 2'd1;
			else if (pop && !push)
				count_q <= count_q - 2'd1;
		end
	end

endmodule

@@ rtl/cvfb_back.sv @@
// Back end: sequencer running the carrier and voice biquad banks on a shared pair of
// multipliers, then envelopes and mix. Holds the coefficient and band-state memories.
// Depends on cvfb_pkg.
module cvfb_back #(
	parameter int MAX_BANDS    = 28,
	parameter int OCTAVE_BANDS = 10,
	parameter int COEF_WIDTH   = 32
) (
	input  logic            clk,
	input  logic            arst_n,
	input  cvfb_pkg::cfg_t  cfg,
	input  cvfb_pkg::item_t q_item,
	input  logic            q_valid,
	output logic            q_pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [23:0]     audio_out,
	output logic [22:0]     out_level
);

	localparam int CW      = (COEF_WIDTH < 32) ? COEF_WIDTH : 32;
	localparam int NB_OCT  = (OCTAVE_BANDS < MAX_BANDS) ? OCTAVE_BANDS : MAX_BANDS;
	localparam int BAND_W  = $clog2(MAX_BANDS);
	localparam int CADDR_W = $clog2(5 * MAX_BANDS);
	localparam int ROW_W   = 4 * 32 + 31;
	localparam int TOT_W   = 48;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_PREP1 = 9'b000000010,
		ST_PREP2 = 9'b000000100,
		ST_MAC   = 9'b000001000,
		ST_RND   = 9'b000010000,
		ST_ENV   = 9'b000100000,
		ST_MIX   = 9'b001000000,
		ST_SUM   = 9'b010000000,
		ST_FIN   = 9'b100000000
	} state_t;

	function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
		logic signed [63:0] b);
		logic signed [64:0] s;
		s = 65'(a) + 65'(b);
		if (s[64] != s[63])
			return s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		return s[63:0];
	endfunction

	function automatic logic signed [31:0] round_q28(logic signed [63:0] acc);
		logic signed [63:0] t;
		logic signed [35:0] s;
		t = sat_add(acc, 64'sd134217728);
		s = 36'(t >>> 28);
		if (s > 36'sd2147483647)
			return 32'sh7FFFFFFF;
		if (s < -36'sd2147483648)
			return 32'sh80000000;
		return s[31:0];
	endfunction

	state_t state_q;
	logic [BAND_W-1:0] band_q;
	logic [2:0] step_q;
	logic hp_q;
	logic signed [23:0] saw_q;
	logic signed [23:0] cin_q [2];
	logic signed [23:0] vin_q [2];
	logic [MAX_BANDS-1:0] row_vld_q;
	logic out_valid_q;
	logic rd_vld_s1;
	logic mul_vld_s2;

	cvfb_pkg::item_t it_q;
	logic [CW-1:0] coef_mem [5 * MAX_BANDS];
	logic [ROW_W-1:0] row_mem [MAX_BANDS];
	logic [CW-1:0] coef_rd_q;
	logic [ROW_W-1:0] row_rd_q;
	logic row_ok_q;
	logic [9:0] q0_q;
	logic [25:0] nfrac_q;
	logic signed [41:0] vprod_q;
	logic signed [23:0] v_q;
	logic [2:0] slot_s1;
	logic signed [63:0] prod_c_s2;
	logic signed [63:0] prod_v_s2;
	logic signed [63:0] acc_c_q;
	logic signed [63:0] acc_v_q;
	logic signed [31:0] yc_q;
	logic signed [31:0] yv_q;
	logic [30:0] a_q;
	logic gt_q;
	logic [30:0] edec_q;
	logic signed [63:0] mix_q;
	logic signed [TOT_W-1:0] tot_q;
	logic [23:0] audio_q;
	logic [22:0] level_q;

	logic cwr_en;
	logic [CADDR_W-1:0] cwr_addr;
	logic [CADDR_W-1:0] crd_addr;
	logic [2:0] cur_slot;
	logic rd_en;
	logic [BAND_W-1:0] last_band;
	logic [ROW_W-1:0] rowv;
	logic signed [31:0] ch0, ch1, vh0, vh1;
	logic [30:0] env_old;
	logic signed [31:0] cf;
	logic signed [31:0] opc, opv;
	logic negate;
	logic signed [63:0] pc, pv;
	logic [25:0] nfrac;
	logic [42:0] qprod;
	logic signed [24:0] vsum;
	logic signed [41:0] vprod_c;
	logic [16:0] rem;
	logic [9:0] qf;
	logic [19:0] saw_step;
	logic signed [25:0] ph;
	logic signed [23:0] saw_n;
	logic signed [25:0] vr;
	logic signed [23:0] v_n;
	logic [32:0] av;
	logic [30:0] a_n;
	logic [53:0] emul;
	logic [30:0] env_n;
	logic [ROW_W-1:0] row_new;
	logic signed [63:0] mix_c;
	logic signed [TOT_W-1:0] tot_n;
	logic [23:0] audio_n;
	logic [22:0] level_n;
	logic fin_go;

	assign q_pop     = (state_q == ST_IDLE) && q_valid;
	assign cwr_en    = q_pop && (q_item.kind == cvfb_pkg::KIND_COEF);
	assign cwr_addr  = CADDR_W'(int'(q_item.band) * 5 + int'(q_item.slot));
	assign last_band = cfg.band_mode ? BAND_W'(MAX_BANDS - 1) : BAND_W'(NB_OCT - 1);
	assign rd_en     = (state_q == ST_MAC) && (step_q <= 3'd4);
	assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_comb begin
		unique case (step_q)
			3'd0: cur_slot = cvfb_pkg::SLOT_B0;
			3'd1: cur_slot = cvfb_pkg::SLOT_B1;
			3'd2: cur_slot = cvfb_pkg::SLOT_B2;
			3'd3: cur_slot = cvfb_pkg::SLOT_A1;
			default: cur_slot = cvfb_pkg::SLOT_A2;
		endcase
	end
	assign crd_addr = CADDR_W'(int'(band_q) * 5 + int'(cur_slot));

	// Band state row: {env, voice hist 1, voice hist 0, carrier hist 1, carrier hist 0}
	assign rowv    = row_ok_q ? row_rd_q : '0;
	assign ch0     = rowv[31:0];
	assign ch1     = rowv[63:32];
	assign vh0     = rowv[95:64];
	assign vh1     = rowv[127:96];
	assign env_old = rowv[158:128];

	assign cf = 32'({coef_rd_q, 32'd0} >> CW);

	always_comb begin
		unique case (slot_s1)
			cvfb_pkg::SLOT_B0: begin
				opc = 32'(saw_q);
				opv = 32'(v_q);
			end
			cvfb_pkg::SLOT_B1: begin
				opc = 32'(cin_q[~hp_q]);
				opv = 32'(vin_q[~hp_q]);
			end
			cvfb_pkg::SLOT_B2: begin
				opc = 32'(cin_q[hp_q]);
				opv = 32'(vin_q[hp_q]);
			end
			cvfb_pkg::SLOT_A1: begin
				opc = hp_q ? ch0 : ch1;
				opv = hp_q ? vh0 : vh1;
			end
			cvfb_pkg::SLOT_A2: begin
				opc = hp_q ? ch1 : ch0;
				opv = hp_q ? vh1 : vh0;
			end
			default: begin
				opc = '0;
				opv = '0;
			end
		endcase
		negate = (slot_s1 == cvfb_pkg::SLOT_A1) || (slot_s1 == cvfb_pkg::SLOT_A2);
		pc = cf * opc;
		pv = cf * opv;
		if (negate) begin
			pc = -pc;
			pv = -pv;
		end
	end

	// sample preparation
	always_comb begin
		nfrac   = 26'(it_q.freq) * 26'(cvfb_pkg::SAW_FRAC_NUM) + 26'(cvfb_pkg::SAW_HALF);
		qprod   = 43'(nfrac) * 43'(cvfb_pkg::SAW_RECIP);
		vsum    = 25'($signed(it_q.left)) + 25'($signed(it_q.right));
		vprod_c = 42'(vsum) * 42'($signed({1'b0, cfg.voice_gain}));
		rem     = 17'(nfrac_q - 26'(q0_q) * 26'(cvfb_pkg::SAW_DEN));
		qf      = q0_q + 10'(rem >= 17'(cvfb_pkg::SAW_DEN));
		saw_step = 20'(it_q.freq) * 20'(cvfb_pkg::SAW_INT) + 20'(qf);
		ph      = 26'(saw_q) + $signed(26'(saw_step));
		saw_n   = (ph >= 26'sd8388608) ? 24'(ph - 26'sd16777216) : 24'(ph);
		vr      = 26'((vprod_q + 42'sd32768) >>> 16);
		if (vr > 26'sd8388607)
			v_n = 24'sh7FFFFF;
		else if (vr < -26'sd8388608)
			v_n = 24'sh800000;
		else
			v_n = 24'(vr);
	end

	// envelope and mix
	always_comb begin
		av   = yv_q[31] ? 33'(-(33'(yv_q))) : 33'(yv_q);
		a_n  = (av > 33'h07FFFFFFF) ? 31'h7FFFFFFF : 31'(av);
		emul = 54'(env_old - a_n) * 54'(cfg.release_coef);
		env_n = gt_q ? a_q : a_q + edec_q;
		mix_c = 64'(yc_q) * 64'($signed({1'b0, env_n}));
		row_new = {env_n,
			hp_q ? yv_q : vh1, hp_q ? vh0 : yv_q,
			hp_q ? yc_q : ch1, hp_q ? ch0 : yc_q};
		tot_n = tot_q + TOT_W'(mix_q >>> 23);
		if (tot_q > TOT_W'(24'sh7FFFFF))
			audio_n = 24'h7FFFFF;
		else if (tot_q < -TOT_W'(24'sh7FFFFF) - TOT_W'(1))
			audio_n = 24'h800000;
		else
			audio_n = tot_q[23:0];
		if (!audio_n[23])
			level_n = audio_n[22:0];
		else if (audio_n == 24'h800000)
			level_n = 23'h7FFFFF;
		else
			level_n = 23'(~audio_n + 24'd1);
	end

	always_ff @(posedge clk) begin
		if (cwr_en)
			coef_mem[cwr_addr] <= q_item.value[31 -: CW];
		if (rd_en)
			coef_rd_q <= coef_mem[crd_addr];
		if (state_q == ST_MIX)
			row_mem[band_q] <= row_new;
		if (state_q == ST_MAC && step_q == 3'd0)
			row_rd_q <= row_mem[band_q];
	end

	always_ff @(posedge clk) begin
		if (q_pop)
			it_q <= q_item;
		if (state_q == ST_PREP1) begin
			q0_q    <= qprod[41:32];
			nfrac_q <= nfrac;
			vprod_q <= vprod_c;
		end
		if (state_q == ST_PREP2) begin
			v_q   <= v_n;
			tot_q <= '0;
		end
		if (state_q == ST_MAC && step_q == 3'd0)
			row_ok_q <= row_vld_q[band_q];
		slot_s1   <= cur_slot;
		prod_c_s2 <= pc;
		prod_v_s2 <= pv;
		if (state_q == ST_MAC && step_q == 3'd0) begin
			acc_c_q <= '0;
			acc_v_q <= '0;
		end else if (mul_vld_s2) begin
			acc_c_q <= sat_add(acc_c_q, prod_c_s2);
			acc_v_q <= sat_add(acc_v_q, prod_v_s2);
		end
		if (state_q == ST_RND) begin
			yc_q <= round_q28(acc_c_q);
			yv_q <= round_q28(acc_v_q);
		end
		if (state_q == ST_ENV) begin
			a_q    <= a_n;
			gt_q   <= a_n > env_old;
			edec_q <= emul[53:23];
		end
		if (state_q == ST_MIX)
			mix_q <= mix_c;
		if (state_q == ST_SUM)
			tot_q <= tot_n;
		if (fin_go) begin
			audio_q <= audio_n;
			level_q <= level_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			band_q      <= '0;
			step_q      <= '0;
			hp_q        <= 1'b0;
			saw_q       <= '0;
			cin_q[0]    <= '0;
			cin_q[1]    <= '0;
			vin_q[0]    <= '0;
			vin_q[1]    <= '0;
			row_vld_q   <= '0;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			mul_vld_s2  <= 1'b0;
		end else begin
			rd_vld_s1  <= rd_en;
			mul_vld_s2 <= rd_vld_s1;
			if (out_ready && !fin_go)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && q_item.kind == cvfb_pkg::KIND_AUDIO)
						state_q <= ST_PREP1;
				end
				ST_PREP1: state_q <= ST_PREP2;
				ST_PREP2: begin
					saw_q   <= saw_n;
					band_q  <= '0;
					step_q  <= '0;
					state_q <= ST_MAC;
				end
				ST_MAC: begin
					if (step_q == 3'd6)
						state_q <= ST_RND;
					else
						step_q <= step_q + 3'd1;
				end
				ST_RND: state_q <= ST_ENV;
				ST_ENV: state_q <= ST_MIX;
				ST_MIX: begin
					row_vld_q[band_q] <= 1'b1;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					step_q <= '0;
					if (band_q == last_band) begin
						state_q <= ST_FIN;
					end else begin
						band_q  <= band_q + BAND_W'(1);
						state_q <= ST_MAC;
					end
				end
				ST_FIN: begin
					if (fin_go) begin
						cin_q[hp_q] <= saw_q;
						vin_q[hp_q] <= v_q;
						hp_q        <= ~hp_q;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign audio_out = audio_q;
	assign out_level = level_q;

endmodule

@@ rtl/channel_vocoder_filter_bank.sv @@
// Channel vocoder filter bank top level: configuration registers, front queue
// and back-end sequencer. Depends on cvfb_pkg, cvfb_front and cvfb_back.
//
// Usage:
//   Input channel (in_valid/in_ready): cmd=0 carries one stereo voice sample and
//   the carrier frequency and yields exactly one output transaction; cmd=1
//   writes one coefficient word (if band and slot are in range), yields nothing.
//   Output channel (out_valid/out_ready): audio_out and its level out_level.
//   Config channel (cfg_valid/cfg_ready): cfg_index selects band_mode (0),
//   release_coef (1) or voice_gain (2); always ready. Write only while idle.
// Processing: the back end runs one band at a time on two shared multipliers:
//   10 bands with band_mode 0 and 28 with band_mode 1 at the default parameters;
//   it takes no new queue item until an audio transaction is finished.
// Output: the result is registered in the final state once the last band is
//   summed and the output is free; a two-entry front queue buffers further inputs.
// Reset: clears the saw phase, all histories and envelopes (band state rows
//   read as zero until first written) and the config registers to defaults.
//   Coefficients are undefined until written.
// Stall: a stalled receiver holds the result; the back end then waits at its
//   final step, the queue fills and in_ready drops.
module channel_vocoder_filter_bank #(
	parameter int MAX_BANDS    = 28,
	parameter int OCTAVE_BANDS = 10,
	parameter int COEF_WIDTH   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        cmd,
	input  logic [23:0] voice_left,
	input  logic [23:0] voice_right,
	input  logic [10:0] carrier_freq,
	input  logic [4:0]  coef_band,
	input  logic [2:0]  coef_slot,
	input  logic [31:0] coef_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [23:0] audio_out,
	output logic [22:0] out_level,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [22:0] cfg_data
);

	cvfb_pkg::cfg_t  cfg_q;
	cvfb_pkg::item_t q_item;
	logic            q_valid;
	logic            q_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.band_mode    <= 1'b0;
			cfg_q.release_coef <= cvfb_pkg::RELEASE_RST;
			cfg_q.voice_gain   <= cvfb_pkg::GAIN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				cvfb_pkg::CFG_BAND_MODE: cfg_q.band_mode    <= cfg_data[0];
				cvfb_pkg::CFG_RELEASE:   cfg_q.release_coef <= cfg_data;
				cvfb_pkg::CFG_GAIN:      cfg_q.voice_gain   <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	cvfb_front #(
		.MAX_BANDS(MAX_BANDS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.cmd         (cmd),
		.voice_left  (voice_left),
		.voice_right (voice_right),
		.carrier_freq(carrier_freq),
		.coef_band   (coef_band),
		.coef_slot   (coef_slot),
		.coef_value  (coef_value),
		.q_item      (q_item),
		.q_valid     (q_valid),
		.q_pop       (q_pop)
	);

	cvfb_back #(
		.MAX_BANDS   (MAX_BANDS),
		.OCTAVE_BANDS(OCTAVE_BANDS),
		.COEF_WIDTH  (COEF_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.q_item   (q_item),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.audio_out(audio_out),
		.out_level(out_level)
	);

endmodule

@@ rtl/cvfb_checker.sv @@
// Port-level checks for the channel vocoder filter bank, bound to the top level.
// Depends on channel_vocoder_filter_bank port names only.
module cvfb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [23:0] audio_out,
	input logic [22:0] out_level,
	input logic        cfg_valid,
	input logic        cfg_ready
);

	logic [23:0] neg_audio;
	assign neg_audio = ~audio_out + 24'd1;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(audio_out))
		else $error("output transaction changed while stalled");

	a_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (!audio_out[23] && out_level == audio_out[22:0]) ||
			(audio_out == 24'h800000 && out_level == 23'h7FFFFF) ||
			(audio_out[23] && audio_out != 24'h800000 && out_level == neg_audio[22:0]))
		else $error("out_level does not match audio_out");

	a_reset: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write stalled");

endmodule

bind channel_vocoder_filter_bank cvfb_checker u_cvfb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.audio_out(audio_out),
	.out_level(out_level),
	.cfg_valid(cfg_valid),
	.cfg_ready(cfg_ready)
);

@@ verif/testbench.sv @@
// Self-checking testbench for channel_vocoder_filter_bank: directed tables, then randomized
// audio and coefficient traffic checked against a bit-accurate predictor of the filter bank.
// Depends on cvfb_pkg and the channel_vocoder_filter_bank RTL.
`timescale 1ns / 1ps

module testbench;

	localparam int BANDS      = 28;
	localparam int OCT_BANDS  = 10;
	localparam int SETTLE     = 400;
	localparam int PHASES     = 6;
	localparam int PHASE_LEN  = 258;
	localparam int HOLD_LEN   = 1500;
	localparam longint S64_MAX = 64'sh7fffffffffffffff;
	localparam longint S64_MIN = -64'sh7fffffffffffffff - 1;

	localparam logic       AUD  = cvfb_pkg::CMD_AUDIO;
	localparam logic       COEF = cvfb_pkg::CMD_COEF;
	localparam logic [2:0] B0   = cvfb_pkg::SLOT_B0;
	localparam logic [2:0] B2   = cvfb_pkg::SLOT_B2;

	typedef struct packed {
		logic        cmd;
		logic [23:0] left;
		logic [23:0] right;
		logic [10:0] freq;
		logic [4:0]  band;
		logic [2:0]  slot;
		logic [31:0] value;
		logic        fixed;
		logic [23:0] exp_audio;
		logic [22:0] exp_level;
	} stim_t;

	// all coefficients are zero here, so every audio transaction must give silence
	localparam stim_t ZERO_TAB [8] = '{
		'{AUD,  24'h7fffff, 24'h7fffff, 11'd100,  5'd0,  3'd0, 32'h0, 1'b1, 24'h0, 23'h0},
		'{AUD,  24'h800000, 24'h800000, 11'd1200, 5'd0,  3'd0, 32'h0, 1'b1, 24'h0, 23'h0},
		'{AUD,  24'h7fffff, 24'h800000, 11'd0,    5'd0,  3'd0, 32'h0, 1'b1, 24'h0, 23'h0},
		'{AUD,  24'h000000, 24'h000000, 11'd2047, 5'd0,  3'd0, 32'h0, 1'b1, 24'h0, 23'h0},
		'{COEF, 24'h0,      24'h0,      11'd0,    5'd31, 3'd0, 32'h7fffffff, 1'b0, 24'h0, 23'h0},
		'{COEF, 24'h0,      24'h0,      11'd0,    5'd0,  3'd7, 32'h80000000, 1'b0, 24'h0, 23'h0},
		'{COEF, 24'h0,      24'h0,      11'd0,    5'd28, 3'd4, 32'hffffffff, 1'b0, 24'h0, 23'h0},
		'{AUD,  24'h400000, 24'h123456, 11'd640,  5'd0,  3'd0, 32'h0, 1'b1, 24'h0, 23'h0}
	};

	localparam stim_t LIVE_TAB [12] = '{
		'{AUD,  24'h7fffff, 24'h7fffff, 11'd1200, 5'd0,  3'd0, 32'h0, 1'b0, 24'h0, 23'h0},
		'{AUD,  24'h800000, 24'h800000, 11'd100,  5'd0,  3'd0, 32'h0, 1'b0, 24'h0, 23'h0},
		'{AUD,  24'h7fffff, 24'h800000, 11'd2047, 5'd0,  3'd0, 32'h0, 1'b0, 24'h0, 23'h0},
		'{AUD,  24'h000000, 24'h000000, 11'd0,    5'd0,  3'd0, 32'h0, 1'b0, 24'h0, 23'h0},
		'{COEF, 24'h0,      24'h0,      11'd0,    5'd0,  B0, 32'h7fffffff, 1'b0, 24'h0, 23'h0},
		'{AUD,  24'h7fffff, 24'h7fffff, 11'd777,  5'd0,  3'd0, 32'h0, 1'b0, 24'h0, 23'h0},
		'{COEF, 24'h0,      24'h0,      11'd0,    5'd0,  B0, 32'h80000000, 1'b0, 24'h0, 23'h0},
		'{AUD,  24'h800000, 24'h7fffff, 11'd300,  5'd0,  3'd0, 32'h0, 1'b0, 24'h0, 23'h0},
		'{COEF, 24'h0,      24'h0,      11'd0,    5'd27, B2, 32'h00000000, 1'b0, 24'h0, 23'h0},
		'{AUD,  24'h000001, 24'hffffff, 11'd555,  5'd0,  3'd0, 32'h0, 1'b0, 24'h0, 23'h0},
		'{COEF, 24'h0,      24'h0,      11'd0,    5'd0,  B0, 32'h01000000, 1'b0, 24'h0, 23'h0},
		'{AUD,  24'h3abcde, 24'hc54321, 11'd1000, 5'd0,  3'd0, 32'h0, 1'b0, 24'h0, 23'h0}
	};

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        cmd;
	logic [23:0] voice_left;
	logic [23:0] voice_right;
	logic [10:0] carrier_freq;
	logic [4:0]  coef_band;
	logic [2:0]  coef_slot;
	logic [31:0] coef_value;
	logic        out_valid;
	logic        out_ready;
	logic [23:0] audio_out;
	logic [22:0] out_level;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [22:0] cfg_data;

	channel_vocoder_filter_bank u_top (.*);

	// predictor state
	logic        mdl_mode;
	logic [22:0] mdl_release;
	logic [15:0] mdl_gain;
	int          saw;
	int          carrier_in [2];
	int          voice_in [2];
	int          carrier_hist [2*BANDS];
	int          voice_hist [2*BANDS];
	longint      envelope [BANDS];
	int          coef_tab [5*BANDS];
	bit          hist_ptr;

	logic [23:0] audio_q [$];
	logic [22:0] level_q [$];
	int          errors;
	int          results_seen;
	int          coef_writes;
	int          sent_count;
	int          tx_idle_pct;
	int          rx_idle_pct;
	bit          hold_done;
	int          hold_left;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("end of test: mismatches");
		$finish;
	end

	function automatic longint sat_add(longint a, longint b);
		longint s;
		s = a + b;
		if (a > 0 && b > 0 && s < 0)
			return S64_MAX;
		if (a < 0 && b < 0 && s >= 0)
			return S64_MIN;
		return s;
	endfunction

	function automatic int biquad_out(int base, int x0, int x1, int x2, int y1, int y2);
		longint acc;
		acc = longint'(coef_tab[base+2]) * x0;
		acc = sat_add(acc, longint'(coef_tab[base+3]) * x1);
		acc = sat_add(acc, longint'(coef_tab[base+4]) * x2);
		acc = sat_add(acc, -(longint'(coef_tab[base]) * y1));
		acc = sat_add(acc, -(longint'(coef_tab[base+1]) * y2));
		acc = sat_add(acc, 64'sd134217728);
		acc = acc >>> 28;
		if (acc > 64'sd2147483647)
			acc = 64'sd2147483647;
		if (acc < -64'sd2147483648)
			acc = -64'sd2147483648;
		return int'(acc);
	endfunction

	task automatic vocode(input stim_t it, output bit has_out, output logic [23:0] a_out,
			output logic [22:0] l_out);
		longint sum, v, total, mag;
		longint step;
		int p, q, nb, yc, yv;
		has_out = 1'b0;
		a_out = '0;
		l_out = '0;
		if (it.cmd == cvfb_pkg::CMD_COEF) begin
			if (it.band < BANDS && it.slot < cvfb_pkg::NUM_SLOTS)
				coef_tab[5*it.band + it.slot] = int'(it.value);
			return;
		end
		sum = longint'($signed(it.left)) + longint'($signed(it.right));
		v = (sum * longint'({1'b0, mdl_gain}) + 32768) >>> 16;
		if (v > 8388607) v = 8388607;
		if (v < -8388608) v = -8388608;
		step = ((longint'(it.freq) << 24) + 22050) / 44100;
		saw = saw + int'(step);
		if (saw >= 8388608)
			saw = saw - 16777216;
		p = hist_ptr;
		q = p ^ 1;
		nb = mdl_mode ? BANDS : OCT_BANDS;
		total = 0;
		for (int i = 0; i < nb; i++) begin
			yc = biquad_out(5*i, saw, carrier_in[q], carrier_in[p],
				carrier_hist[2*i+q], carrier_hist[2*i+p]);
			yv = biquad_out(5*i, int'(v), voice_in[q], voice_in[p],
				voice_hist[2*i+q], voice_hist[2*i+p]);
			carrier_hist[2*i+p] = yc;
			voice_hist[2*i+p] = yv;
			mag = yv < 0 ? -longint'(yv) : longint'(yv);
			if (mag > 64'sd2147483647)
				mag = 64'sd2147483647;
			if (mag > envelope[i])
				envelope[i] = mag;
			else
				envelope[i] = mag + (((envelope[i] - mag) * longint'({1'b0, mdl_release})) >>> 23);
			total += (longint'(yc) * envelope[i]) >>> 23;
		end
		carrier_in[p] = saw;
		voice_in[p] = int'(v);
		hist_ptr = q[0];
		if (total > 8388607) total = 8388607;
		if (total < -8388608) total = -8388608;
		has_out = 1'b1;
		a_out = total[23:0];
		mag = total < 0 ? (total == -8388608 ? 8388607 : -total) : total;
		l_out = mag[22:0];
	endtask

	task automatic send_item(input stim_t it);
		bit has_out;
		logic [23:0] a_out;
		logic [22:0] l_out;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= it.cmd;
		voice_left <= it.left;
		voice_right <= it.right;
		carrier_freq <= it.freq;
		coef_band <= it.band;
		coef_slot <= it.slot;
		coef_value <= it.value;
		do @(negedge clk); while (!in_ready);
		@(posedge clk);
		sent_count++;
		vocode(it, has_out, a_out, l_out);
		if (it.cmd == cvfb_pkg::CMD_COEF)
			coef_writes++;
		if (has_out) begin
			audio_q.push_back(it.fixed ? it.exp_audio : a_out);
			level_q.push_back(it.fixed ? it.exp_level : l_out);
		end
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [22:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			cvfb_pkg::CFG_BAND_MODE: mdl_mode = data[0];
			cvfb_pkg::CFG_RELEASE:   mdl_release = data;
			cvfb_pkg::CFG_GAIN:      mdl_gain = data[15:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (audio_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	function automatic logic [31:0] stable_coef(logic [2:0] slot);
		case (slot)
			cvfb_pkg::SLOT_A1: return 32'($urandom_range(0, 1020000000)) - 32'd510000000;
			cvfb_pkg::SLOT_A2: return 32'($urandom_range(134217728, 255013683));
			cvfb_pkg::SLOT_B1: return 32'($urandom_range(0, 8388608)) - 32'd4194304;
			default: return 32'($urandom_range(0, 67108864)) - 32'd33554432;
		endcase
	endfunction

	function automatic stim_t random_item();
		stim_t it;
		it = '0;
		it.left = 24'($urandom);
		it.right = 24'($urandom);
		it.freq = $urandom_range(0, 9) == 0 ? 11'($urandom) : 11'($urandom_range(100, 1200));
		it.band = 5'($urandom_range(0, BANDS - 1));
		it.slot = 3'($urandom_range(0, cvfb_pkg::NUM_SLOTS - 1));
		it.value = stable_coef(it.slot);
		if ($urandom_range(0, 9) == 0) begin
			it.cmd = cvfb_pkg::CMD_COEF;
			case ($urandom_range(0, 5))
				0: it.band = 5'($urandom_range(BANDS, 31));
				1: it.slot = 3'($urandom_range(cvfb_pkg::NUM_SLOTS, 7));
				2: it.value = $urandom;
				default: ;
			endcase
		end else begin
			it.cmd = cvfb_pkg::CMD_AUDIO;
			if ($urandom_range(0, 3) == 0) begin
				it.left = 24'($signed(24'($urandom_range(0, 8191))) - 24'sd4096);
				it.right = 24'($signed(24'($urandom_range(0, 8191))) - 24'sd4096);
			end
		end
		return it;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (!hold_done && sent_count >= 1700) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_LEN;
			hold_done <= 1'b1;
		end else begin
			out_ready <= $urandom_range(0, 99) >= rx_idle_pct;
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (audio_q.size() == 0) begin
				$display("%0t: unexpected transaction audio_out=%h out_level=%h",
					$time, audio_out, out_level);
				errors++;
			end else begin
				if (audio_out !== audio_q[0]) begin
					$display("%0t: audio_out expected %h actual %h", $time, audio_q[0], audio_out);
					errors++;
				end
				if (out_level !== level_q[0]) begin
					$display("%0t: out_level expected %h actual %h", $time, level_q[0], out_level);
					errors++;
				end
				void'(audio_q.pop_front());
				void'(level_q.pop_front());
				results_seen++;
			end
		end
	end

	logic        ph_mode [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
	logic [22:0] ph_release [PHASES] = '{23'd8388433, 23'd8388607, 23'd0, 23'd0, 23'd8000000, 23'd0};
	logic [22:0] ph_gain [PHASES] = '{23'd1311, 23'h7fffff, 23'h7f0000, 23'd0, 23'd20000, 23'd0};

	initial begin
		stim_t it;
		arst_n = 1'b0;
		in_valid = 1'b0;
		cmd = cvfb_pkg::CMD_AUDIO;
		voice_left = '0;
		voice_right = '0;
		carrier_freq = '0;
		coef_band = '0;
		coef_slot = '0;
		coef_value = '0;
		cfg_valid = 1'b0;
		cfg_index = cvfb_pkg::CFG_BAND_MODE;
		cfg_data = '0;
		mdl_mode = 1'b0;
		mdl_release = cvfb_pkg::RELEASE_RST;
		mdl_gain = cvfb_pkg::GAIN_RST;
		saw = 0;
		hist_ptr = 1'b0;
		carrier_in = '{0, 0};
		voice_in = '{0, 0};
		foreach (carrier_hist[i]) begin
			carrier_hist[i] = 0;
			voice_hist[i] = 0;
		end
		foreach (envelope[i]) envelope[i] = 0;
		foreach (coef_tab[i]) coef_tab[i] = 0;
		errors = 0;
		results_seen = 0;
		coef_writes = 0;
		sent_count = 0;
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		it = '0;
		it.cmd = cvfb_pkg::CMD_COEF;
		for (int i = 0; i < 5*BANDS; i++) begin
			it.band = 5'(i / 5);
			it.slot = 3'(i % 5);
			send_item(it);
		end
		foreach (ZERO_TAB[i]) send_item(ZERO_TAB[i]);
		for (int i = 0; i < 5*BANDS; i++) begin
			it.band = 5'(i / 5);
			it.slot = 3'(i % 5);
			it.value = stable_coef(it.slot);
			send_item(it);
		end
		foreach (LIVE_TAB[i]) send_item(LIVE_TAB[i]);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_reg(cvfb_pkg::CFG_BAND_MODE,
				ph_mode[ph] ? 23'h7ffffe | 23'd1 : 23'h2aaaaa & ~23'd1);
			write_reg(cvfb_pkg::CFG_RELEASE,
				ph == 3 || ph == 5 ? 23'($urandom) : ph_release[ph]);
			write_reg(cvfb_pkg::CFG_GAIN, ph == 3 || ph == 5 ? 23'($urandom) : ph_gain[ph]);
			for (int n = 0; n < PHASE_LEN; n++) begin
				if (ph < 2) begin
					tx_idle_pct = 6;
					rx_idle_pct = 85;
				end else if (ph < 4) begin
					tx_idle_pct = 85;
					rx_idle_pct = 6;
				end else begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				send_item(random_item());
			end
		end
		in_valid <= 1'b0;
		while (audio_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (audio_q.size() != 0)
			errors++;

		$display("covered %0d audio results and %0d coefficient writes over %0d band/gain settings",
			results_seen, coef_writes, PHASES);
		if (errors == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/cvfb_pkg.sv
rtl/cvfb_front.sv
rtl/cvfb_back.sv
rtl/channel_vocoder_filter_bank.sv
rtl/cvfb_checker.sv
verif/testbench.sv
